/* design/czs_pkg.sv */
// Shared types and constants for the charge region zero suppressor.
// Used by every module of the block; depends on nothing.
package czs_pkg;

  // Frame length in ticks; ticks at or beyond it do not touch region state.
  localparam int unsigned MAX_TICKS   = 4096;
  localparam int unsigned TICK_CMP_W  = 17;
  // Zero ticks kept inside a region before it closes.
  localparam logic [1:0]  GAP_LIMIT   = 2'd3;
  localparam logic [14:0] SAMPLE_MAX  = 15'h7FFF;
  localparam logic [39:0] ROUND_HALF  = 40'h0000008000;
  localparam logic [15:0] INV_GAIN_RST = 16'd818;
  // Result slots one input beat can produce.
  localparam int unsigned MAX_RESULTS = 5;
  localparam int unsigned CNT_W       = 3;
  // Configuration port.
  localparam int unsigned CFG_AW      = 3;
  localparam int unsigned CFG_DW      = 32;
  localparam logic        REG_INV_GAIN = 1'b0;

  // Input beat.
  typedef struct packed {
    logic [15:0] channel_id;
    logic [11:0] tick;
    logic [23:0] charge_electrons;
    logic        last_tick;
  } in_beat_t;

  // Result beat.
  typedef struct packed {
    logic [15:0] channel_id_out;
    logic [11:0] region_start;
    logic [11:0] sample_offset;
    logic [14:0] sample_value;
    logic        region_end;
  } out_beat_t;

  // Beat after scaling, handed from the scaler to the region tracker.
  typedef struct packed {
    logic [15:0] channel_id;
    logic [11:0] tick;
    logic [14:0] value;
    logic        charged;
    logic        last_tick;
  } scaled_t;

  // All results of one input beat, in order, with their count.
  typedef struct packed {
    logic [CNT_W-1:0]                  count;
    out_beat_t [MAX_RESULTS-1:0]       items;
  } burst_t;

endpackage

/* design/czs_scale.sv */
// Input register and gain scaling stage: multiply, round half up, saturate.
// Depends on czs_pkg.
module czs_scale (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [15:0]       inv_gain,
  input  logic              in_valid,
  output logic              in_ready,
  input  czs_pkg::in_beat_t in_data,
  output logic              s_valid,
  input  logic              s_ready,
  output czs_pkg::scaled_t  s_data
);
  import czs_pkg::*;

  logic        s1_valid_r;
  in_beat_t    s1_data_r;
  logic        s2_valid_r;
  scaled_t     s2_data_r;
  logic        s1_move;
  logic [39:0] prod;
  logic [39:0] rounded;
  scaled_t     s2_nxt;

  // Each stage takes a new beat when it is empty or its beat moves on.
  assign s1_move  = s1_valid_r && (!s2_valid_r || s_ready);
  assign in_ready = !s1_valid_r || s1_move;

  // Exact Q24.16 product, then round half up and saturate to 15 bits.
  always_comb begin
    prod    = 40'(s1_data_r.charge_electrons) * 40'(inv_gain);
    rounded = (prod + ROUND_HALF) >> 16;
    s2_nxt.channel_id = s1_data_r.channel_id;
    s2_nxt.tick       = s1_data_r.tick;
    s2_nxt.value      = (rounded > 40'(SAMPLE_MAX)) ? SAMPLE_MAX : rounded[14:0];
    s2_nxt.charged    = (prod != 40'd0);
    s2_nxt.last_tick  = s1_data_r.last_tick;
  end

  // Valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (!s2_valid_r || s_ready) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
    if (s1_move) begin
      s2_data_r <= s2_nxt;
    end
  end

  assign s_valid = s2_valid_r;
  assign s_data  = s2_data_r;

endmodule

/* design/czs_region.sv */
// Region tracker: opens, extends and closes regions and builds the result burst.
// Depends on czs_pkg.
module czs_region (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             s_valid,
  output logic             s_ready,
  input  czs_pkg::scaled_t s_data,
  output logic             b_valid,
  input  logic             b_ready,
  output czs_pkg::burst_t  b_data
);
  import czs_pkg::*;

  logic        open_r,  open_nxt;
  logic [11:0] start_r, start_nxt;
  logic [12:0] len_r,   len_nxt;
  logic [1:0]  gap_r,   gap_nxt;
  logic [15:0] chan_r,  chan_nxt;
  logic        take;

  function automatic out_beat_t mk_res(input logic [15:0] ch, input logic [11:0] st,
                                       input logic [11:0] off, input logic [14:0] val,
                                       input logic fin);
    out_beat_t r;
    r.channel_id_out = ch;
    r.region_start   = st;
    r.sample_offset  = off;
    r.sample_value   = val;
    r.region_end     = fin;
    return r;
  endfunction

  assign s_ready = b_ready;
  assign b_valid = s_valid;
  assign take    = s_valid && b_ready;

  // Walk the beat against the region state and list its results in order.
  always_comb begin
    logic [CNT_W-1:0] n;
    logic             in_frame;
    logic [11:0]      off;
    n         = '0;
    off       = '0;
    b_data    = '0;
    open_nxt  = open_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    gap_nxt   = gap_r;
    chan_nxt  = chan_r;
    in_frame  = (TICK_CMP_W'(s_data.tick) < TICK_CMP_W'(MAX_TICKS));

    // A new channel closes the old channel's region first.
    if (s_data.channel_id != chan_r) begin
      if (open_r) begin
        b_data.items[n] = mk_res(chan_r, start_r, 12'd0, 15'd0, 1'b1);
        n = n + 1'b1;
      end
      open_nxt = 1'b0;
      len_nxt  = '0;
      gap_nxt  = '0;
      chan_nxt = s_data.channel_id;
    end

    if (in_frame) begin
      if (s_data.charged) begin
        if (!open_nxt) begin
          open_nxt  = 1'b1;
          start_nxt = s_data.tick;
          len_nxt   = '0;
        end else begin
          // Held gap ticks go out as zero samples ahead of the new one.
          for (int k = 0; k < 3; k++) begin
            if (2'(k) < gap_nxt) begin
              off = len_nxt[12] ? 12'hFFF : len_nxt[11:0];
              b_data.items[n] = mk_res(chan_nxt, start_nxt, off, 15'd0, 1'b0);
              n = n + 1'b1;
              if (!len_nxt[12]) begin
                len_nxt = len_nxt + 1'b1;
              end
            end
          end
        end
        off = len_nxt[12] ? 12'hFFF : len_nxt[11:0];
        b_data.items[n] = mk_res(chan_nxt, start_nxt, off, s_data.value, 1'b0);
        n = n + 1'b1;
        if (!len_nxt[12]) begin
          len_nxt = len_nxt + 1'b1;
        end
        gap_nxt = '0;
      end else if (gap_nxt == GAP_LIMIT) begin
        if (open_nxt) begin
          b_data.items[n] = mk_res(chan_nxt, start_nxt, 12'd0, 15'd0, 1'b1);
          n = n + 1'b1;
        end
        open_nxt = 1'b0;
        len_nxt  = '0;
        gap_nxt  = '0;
      end else begin
        gap_nxt = gap_nxt + 1'b1;
      end
    end

    // The last tick of a channel flushes whatever is open.
    if (s_data.last_tick) begin
      if (open_nxt) begin
        b_data.items[n] = mk_res(chan_nxt, start_nxt, 12'd0, 15'd0, 1'b1);
        n = n + 1'b1;
      end
      open_nxt = 1'b0;
      len_nxt  = '0;
      gap_nxt  = '0;
    end

    b_data.count = n;
  end

  // Region state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r  <= 1'b0;
      start_r <= '0;
      len_r   <= '0;
      gap_r   <= '0;
      chan_r  <= '0;
    end else if (take) begin
      open_r  <= open_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
      gap_r   <= gap_nxt;
      chan_r  <= chan_nxt;
    end
  end

endmodule

/* design/czs_outq.sv */
// Output queue: holds one burst of results and sends them one beat at a time.
// Depends on czs_pkg.
module czs_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               b_valid,
  output logic               b_ready,
  input  czs_pkg::burst_t    b_data,
  output logic               out_valid,
  input  logic               out_ready,
  output czs_pkg::out_beat_t out_data
);
  import czs_pkg::*;

  out_beat_t        buf_r [MAX_RESULTS];
  logic [CNT_W-1:0] cnt_r;
  logic             pop;
  logic             load;

  assign out_valid = (cnt_r != '0);
  assign out_data  = buf_r[0];
  assign pop       = out_valid && out_ready;
  // A new burst may enter once the queue is empty or its last beat leaves now.
  assign b_ready   = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && out_ready);
  assign load      = b_valid && b_ready;

  // Fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= b_data.count;
    end else if (pop) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // Entries shift toward the head as beats leave.
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        buf_r[i] <= b_data.items[i];
      end
    end else if (pop) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        buf_r[i] <= buf_r[i+1];
      end
    end
  end

endmodule

/* design/charge_roi_zero_suppressor.sv */
// Top level of the charge region zero suppressor: gain register, scaler,
// region tracker and output queue. Depends on czs_pkg, czs_scale, czs_region, czs_outq.
//
//   Port group | Handshake           | Payload
//   in_        | in_valid/in_ready   | in_data (czs_pkg::in_beat_t)
//   out_       | out_valid/out_ready | out_data (czs_pkg::out_beat_t)
//   cfg_       | APB, pready high    | inv_gain at byte address 0
//
// A beat is accepted every cycle while out_ready is high and each beat yields at most
// one result. A beat with more results (up to five) holds back the next beat until
// the last of them leaves the single-burst output queue.
// Reset is synchronous and needs no clearing pass; in_ready is high right after it.
// A stalled output backs up through the queue, then the two scaler stages.
module charge_roi_zero_suppressor (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  czs_pkg::in_beat_t            in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output czs_pkg::out_beat_t           out_data,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [czs_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [czs_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [czs_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready
);
  import czs_pkg::*;

  logic [15:0] inv_gain_r;
  logic        s_valid, s_ready;
  scaled_t     s_data;
  logic        b_valid, b_ready;
  burst_t      b_data;
  logic        reg_hit;

  // Configuration register; the word index is the address above the byte bits.
  assign cfg_pready = 1'b1;
  assign reg_hit    = (cfg_paddr[CFG_AW-1:2] == REG_INV_GAIN);
  assign cfg_prdata = reg_hit ? CFG_DW'(inv_gain_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_gain_r <= INV_GAIN_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_hit) begin
      inv_gain_r <= cfg_pwdata[15:0];
    end
  end

  czs_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .inv_gain (inv_gain_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .s_data   (s_data)
  );

  czs_region u_region (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .b_valid (b_valid),
    .b_ready (b_ready),
    .b_data  (b_data)
  );

  czs_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .b_valid   (b_valid),
    .b_ready   (b_ready),
    .b_data    (b_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* design/czs_checker.sv */
// Port-level checks for the charge region zero suppressor, bound to the top.
// Depends on czs_pkg and charge_roi_zero_suppressor.
module czs_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input czs_pkg::out_beat_t           out_data
);
  import czs_pkg::*;

  // A result beat that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // End markers carry no sample.
  a_end_clean: assert property (@(posedge clk)
    out_valid && out_data.region_end |->
      out_data.sample_offset == 12'd0 && out_data.sample_value == 15'd0)
    else $error("end marker with sample fields set");

  // Reset empties the queue and the scaler stages.
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not empty after reset");

  // A fresh region starts its samples at offset zero after an end marker
  // of a different region start on the same channel.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.region_end ##1
      out_valid && !out_data.region_end &&
      out_data.channel_id_out == $past(out_data.channel_id_out) &&
      out_data.region_start != $past(out_data.region_start) |->
      out_data.sample_offset == 12'd0)
    else $error("new region does not start at offset zero");

endmodule

bind charge_roi_zero_suppressor czs_checker u_czs_checker (.*);

/* tb/tb_charge_roi_zero_suppressor.sv */
`timescale 1ns / 1ps
// Self-checking testbench for charge_roi_zero_suppressor: directed, gain, long-region,
// backpressure and random tests against an in-bench region predictor.
// Depends on czs_pkg and the charge_roi_zero_suppressor RTL.
module tb_charge_roi_zero_suppressor;
  import czs_pkg::*;

  localparam int IDLE_LIMIT    = 5000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_PRINTED   = 30;
  localparam logic [CFG_AW-1:0] GAIN_ADDR = CFG_AW'(4 * REG_INV_GAIN);

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_beat_t in_data;
  logic out_valid;
  logic out_ready = 1'b0;
  out_beat_t out_data;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  // Idle and stall rates in percent, plus a long receiver hold-off request.
  int in_gap_pct = 0;
  int out_stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;

  int beats_sent = 0;
  int results_checked = 0;
  int end_markers = 0;
  int err_count = 0;
  int stalled_cycles = 0;

  // Predictor state: gain register and region tracker.
  logic [15:0] gain_q16 = INV_GAIN_RST;
  bit roi_open = 1'b0;
  logic [11:0] roi_start = '0;
  logic [12:0] roi_len = '0;
  logic [1:0] zero_run = '0;
  logic [15:0] cur_chan = '0;
  out_beat_t pending_results[$];

  charge_roi_zero_suppressor dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Region predictor.
  function automatic void push_result(logic [11:0] off, logic [14:0] val, bit is_end);
    out_beat_t r;
    r.channel_id_out = cur_chan;
    r.region_start = roi_start;
    r.sample_offset = off;
    r.sample_value = val;
    r.region_end = is_end;
    pending_results = {pending_results, r};
  endfunction

  function automatic void push_sample(logic [14:0] val);
    push_result((roi_len > 13'd4095) ? 12'hFFF : roi_len[11:0], val, 1'b0);
    if (roi_len < 13'd4096) roi_len++;
  endfunction

  function automatic void close_roi();
    if (roi_open) push_result('0, '0, 1'b1);
    roi_open = 1'b0;
    roi_len = '0;
  endfunction

  function automatic void track_regions(in_beat_t b);
    logic [39:0] prod;
    logic [24:0] scaled;
    logic [14:0] val;
    if (b.channel_id != cur_chan) begin
      close_roi();
      zero_run = '0;
      cur_chan = b.channel_id;
    end
    if (int'(b.tick) < MAX_TICKS) begin
      prod = 40'(b.charge_electrons) * 40'(gain_q16);
      if (prod != '0) begin
        scaled = 25'((prod + ROUND_HALF) >> 16);
        val = (scaled > 25'(SAMPLE_MAX)) ? SAMPLE_MAX : scaled[14:0];
        if (!roi_open) begin
          roi_open = 1'b1;
          roi_start = b.tick;
          roi_len = '0;
        end else begin
          // Gap ticks inside the region come out as zero samples.
          repeat (zero_run) push_sample('0);
        end
        push_sample(val);
        zero_run = '0;
      end else if (zero_run >= GAP_LIMIT) begin
        close_roi();
        zero_run = '0;
      end else begin
        zero_run++;
      end
    end
    if (b.last_tick) begin
      close_roi();
      zero_run = '0;
    end
  endfunction

  function automatic in_beat_t beat(logic [15:0] ch, logic [11:0] t, logic [23:0] q,
                                    logic last);
    in_beat_t b;
    b.channel_id = ch;
    b.tick = t;
    b.charge_electrons = q;
    b.last_tick = last;
    return b;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    if (err_count < MAX_PRINTED)
      $display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    err_count++;
  endtask

  // Send one input beat, with random idle cycles ahead of it, and predict its results.
  task automatic send_beat(in_beat_t b);
    @(negedge clk);
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (!in_ready);
    track_regions(b);
    beats_sent++;
  endtask

  // Drop valid, wait for every expected result, then let the pipeline settle.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_access(bit wr, logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] wdata,
                            output logic [CFG_DW-1:0] rdata);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= addr;
    cfg_pwdata <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // Write the gain once the block is idle, then read it back.
  task automatic program_gain(logic [15:0] value);
    logic [CFG_DW-1:0] rd;
    wait_idle();
    cfg_access(1'b1, GAIN_ADDR, CFG_DW'(value), rd);
    gain_q16 = value;
    cfg_access(1'b0, GAIN_ADDR, '0, rd);
    if (rd[15:0] !== value) report_mismatch("inv_gain readback", rd[15:0], value);
  endtask

  function automatic logic [15:0] pick_channel();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 16'h0000;
    if (r < 20) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [23:0] pick_charge();
    int r;
    r = $urandom_range(99);
    if (r < 15) return 24'($urandom_range(1, 80));
    if (r < 25) return 24'hFFFFFF - 24'($urandom_range(0, 255));
    if (r < 45) return 24'($urandom);
    return 24'($urandom_range(100, 400000));
  endfunction

  // Directed: gap fill, gap close, saturation, charged-but-zero sample, channel
  // change, flush, a beat with the most results, and field extremes.
  task automatic test_directed_regions();
    send_beat(beat(16'h0000, 12'd0, 24'd0, 1'b0));
    send_beat(beat(16'h0000, 12'd1, 24'd1000, 1'b0));
    send_beat(beat(16'h0000, 12'd2, 24'd0, 1'b0));
    send_beat(beat(16'h0000, 12'd3, 24'd0, 1'b0));
    send_beat(beat(16'h0000, 12'd4, 24'd0, 1'b0));
    send_beat(beat(16'h0000, 12'd5, 24'd2000, 1'b0));
    for (int i = 6; i < 10; i++) send_beat(beat(16'h0000, 12'(i), 24'd0, 1'b0));
    send_beat(beat(16'h0000, 12'd10, 24'hFFFFFF, 1'b0));
    send_beat(beat(16'h0000, 12'd11, 24'd40, 1'b0));
    send_beat(beat(16'hFFFF, 12'hFFF, 24'd1, 1'b0));
    for (int i = 0; i < 3; i++) send_beat(beat(16'hFFFF, 12'(i), 24'd0, 1'b0));
    send_beat(beat(16'hFFFF, 12'd3, 24'h800000, 1'b1));
    send_beat(beat(16'h5A5A, 12'hA5A, 24'h5A5A5A, 1'b1));
    send_beat(beat(16'hA5A5, 12'h5A5, 24'hA5A5A5, 1'b0));
    send_beat(beat(16'hA5A5, 12'h5A6, 24'd0, 1'b1));
    send_beat(beat(16'hA5A5, 12'd100, 24'd0, 1'b1));
  endtask

  // Gain extremes: rounding at the half point, saturation, and a zero gain.
  task automatic test_gain_extremes();
    program_gain(16'd1);
    send_beat(beat(16'd1, 12'd0, 24'd32767, 1'b0));
    send_beat(beat(16'd1, 12'd1, 24'd32768, 1'b0));
    send_beat(beat(16'd1, 12'd2, 24'hFFFFFF, 1'b1));
    program_gain(16'hFFFF);
    send_beat(beat(16'd2, 12'd0, 24'd1, 1'b0));
    send_beat(beat(16'd2, 12'd1, 24'hFFFFFF, 1'b1));
    program_gain(16'd0);
    send_beat(beat(16'd3, 12'd0, 24'hFFFFFF, 1'b0));
    send_beat(beat(16'd3, 12'd1, 24'd1234, 1'b0));
    send_beat(beat(16'd3, 12'd2, 24'd77, 1'b1));
    program_gain(INV_GAIN_RST);
  endtask

  // One long region whose ticks wrap past the end of the frame.
  task automatic test_long_region();
    in_gap_pct = 0;
    out_stall_pct = 0;
    for (int i = 0; i < 64; i++)
      send_beat(beat(16'h0042, 12'(4064 + i), 24'(1000 + i % 500), i == 63));
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering beats.
  task automatic test_backpressure();
    in_gap_pct = 0;
    out_stall_pct = 0;
    hold_request = 400;
    for (int i = 0; i < 80; i++)
      send_beat(beat(16'h0077, 12'(i), (i % 7 == 3) ? 24'd0 : pick_charge(), i == 79));
  endtask

  // Random channel runs made of charged and silent stretches, with some noise beats.
  task automatic test_random_traffic(int gap_pct, int stall_pct, int n_beats,
                                     logic [15:0] gain);
    logic [15:0] ch;
    logic [11:0] t;
    int len;
    int seg_left;
    bit silent;
    int stop_at;
    program_gain(gain);
    in_gap_pct = gap_pct;
    out_stall_pct = stall_pct;
    stop_at = beats_sent + n_beats;
    silent = 1'b0;
    while (beats_sent < stop_at) begin
      ch = ($urandom_range(99) < 15) ? cur_chan : pick_channel();
      t = 12'($urandom_range(0, 4095));
      len = $urandom_range(4, 24);
      seg_left = 0;
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(99) < 6) begin
          send_beat(beat(pick_channel(), 12'($urandom), 24'($urandom), 1'($urandom)));
        end else begin
          if (seg_left == 0) begin
            silent = $urandom_range(99) < 45;
            seg_left = silent ? $urandom_range(1, 5) : $urandom_range(1, 6);
          end
          send_beat(beat(ch, t, silent ? 24'd0 : pick_charge(),
                         (k == len - 1) && ($urandom_range(99) < 80)));
          seg_left--;
        end
        t++;
      end
    end
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= $urandom_range(99) >= out_stall_pct;
    end
  end

  // Compare each accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result beat", out_data, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.channel_id_out !== want.channel_id_out)
          report_mismatch("channel_id_out", out_data.channel_id_out, want.channel_id_out);
        if (out_data.region_start !== want.region_start)
          report_mismatch("region_start", out_data.region_start, want.region_start);
        if (out_data.sample_offset !== want.sample_offset)
          report_mismatch("sample_offset", out_data.sample_offset, want.sample_offset);
        if (out_data.sample_value !== want.sample_value)
          report_mismatch("sample_value", out_data.sample_value, want.sample_value);
        if (out_data.region_end !== want.region_end)
          report_mismatch("region_end", out_data.region_end, want.region_end);
        if (want.region_end) end_markers++;
      end
      results_checked++;
    end
  end

  // Watchdog on cycles without any accepted beat or register access.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_psel && cfg_penable)) begin
      stalled_cycles = 0;
    end else begin
      stalled_cycles++;
    end
    if (stalled_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no progress for %0d cycles, %0d results still expected",
               IDLE_LIMIT, pending_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_regions();
    test_gain_extremes();
    test_long_region();
    test_backpressure();
    test_random_traffic(14, 58, 80, 16'($urandom_range(1, 4000)));
    test_random_traffic(58, 14, 70, 16'($urandom_range(1, 65535)));
    test_random_traffic(0, 0, 70, INV_GAIN_RST);

    wait_idle();
    if (pending_results.size() != 0)
      report_mismatch("results never produced", pending_results.size(), 0);
    $display("Run covered %0d input beats and %0d result beats, %0d of them region ends,",
             beats_sent, results_checked, end_markers);
    $display("over gains from zero to full scale, three idle profiles and a long stall.");
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches found", err_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
